[src/rcfc_pkg.sv]
`default_nettype none
package rcfc_pkg;

   localparam int FIELD_W = 18;
   localparam int RATE_W = 23;
   localparam int PROD_W = 41;
   localparam int CROSS_W = 42;
   localparam int MAG_W = 41;
   localparam int NUM_W = 50;
   localparam int DEN_W = 27;
   localparam int GAIN_W = 24;
   localparam int ILIM_W = 20;
   localparam int DLIM_W = 16;
   localparam int CUR_W = 21;
   localparam int AXES = 3;

   // Quotient bits kept by the dividers; anything larger saturates, since
   // every limit is below two to the power of this.
   localparam int QBITS = 21;
   // One stage for the saturation test, then one stage per quotient bit.
   localparam int DIV_STAGES = QBITS + 1;
   localparam int FRONT_STAGES = 4;
   // Front stages, divider stages and the result register.
   localparam int NUM_STAGES = FRONT_STAGES + DIV_STAGES + 1;

   // 67200 / 1000 = 336 / 5, so the dipole scale goes to the numerator and
   // the five to the divisor.
   localparam logic [8:0] DIPOLE_SCALE = 9'd336;
   localparam logic [2:0] GAIN_SCALE = 3'd5;
   localparam logic [29:0] DLIM_SCALE = 30'd1_000_000_000;

   typedef enum logic [2:0] {
      REG_GAIN_X = 3'd0,
      REG_GAIN_Y = 3'd1,
      REG_GAIN_Z = 3'd2,
      REG_ILIM_X = 3'd3,
      REG_ILIM_Y = 3'd4,
      REG_ILIM_Z = 3'd5,
      REG_DLIM   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      logic [ILIM_W-1:0] ilim;
      logic [DLIM_W-1:0] dlim;
   } axis_cfg_type;

   typedef struct packed {
      logic neg;
      logic off;
      logic [ILIM_W-1:0] ilim;
   } tag_type;

   typedef struct packed {
      tag_type tag;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic [NUM_W-1:0] lnum;
      logic [DEN_W-1:0] lden;
   } axis_in_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [QBITS-1:0] q;
      logic sat;
   } div_type;

   function automatic div_type div_start(logic [NUM_W-1:0] num, logic [DEN_W-1:0] den);
      div_type r;
      r.rem = num;
      r.den = den;
      r.q = '0;
      r.sat = (num >= (NUM_W'(den) << QBITS));
      return r;
   endfunction

   function automatic div_type div_step(div_type s, logic [NUM_W-1:0] dsh,
                                        logic [QBITS-1:0] qbit);
      div_type r;
      r = s;
      if (s.rem >= dsh) begin
         r.rem = s.rem - dsh;
         r.q = s.q | qbit;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[src/rcfc_front.sv]
`default_nettype none
module rcfc_front
   import rcfc_pkg::*;
(
   input  wire logic clock,
   input  wire logic [FRONT_STAGES-1:0] adv,
   input  wire logic signed [FIELD_W-1:0] field [AXES],
   input  wire logic signed [RATE_W-1:0] rate [AXES],
   input  wire axis_cfg_type cfg [AXES],
   output axis_in_type ax [AXES],
   output logic zero
);

   logic signed [FIELD_W-1:0] field_ff [AXES];
   logic signed [RATE_W-1:0] rate_ff [AXES];
   logic signed [PROD_W-1:0] pa_ff [AXES], pa_in [AXES];
   logic signed [PROD_W-1:0] pb_ff [AXES], pb_in [AXES];
   logic signed [CROSS_W-1:0] c_ff [AXES], c_in [AXES];
   axis_in_type ax_ff [AXES], ax_in [AXES];
   logic z1_ff, z1_in, z2_ff, z3_ff;

   assign z1_in = (field_ff[0] == '0) && (field_ff[1] == '0) && (field_ff[2] == '0);

   for (genvar a = 0; a < AXES; a++) begin : g_axis
      localparam int A1 = (a + 1) % AXES;
      localparam int A2 = (a + 2) % AXES;
      logic [MAG_W-1:0] mag;

      assign pa_in[a] = rate_ff[A1] * field_ff[A2];
      assign pb_in[a] = rate_ff[A2] * field_ff[A1];
      assign c_in[a] = CROSS_W'(pa_ff[a]) - CROSS_W'(pb_ff[a]);
      assign mag = c_ff[a][CROSS_W-1] ? MAG_W'(-c_ff[a]) : MAG_W'(c_ff[a]);

      always_comb begin
         ax_in[a].tag.neg = c_ff[a][CROSS_W-1];
         ax_in[a].tag.off = z2_ff || (cfg[a].gain == '0) || (cfg[a].ilim == '0)
                            || (cfg[a].dlim == '0);
         ax_in[a].tag.ilim = cfg[a].ilim;
         ax_in[a].num = NUM_W'(mag) * NUM_W'(DIPOLE_SCALE);
         ax_in[a].den = DEN_W'(cfg[a].gain) * DEN_W'(GAIN_SCALE);
         ax_in[a].lnum = NUM_W'(cfg[a].dlim) * NUM_W'(DLIM_SCALE);
         ax_in[a].lden = DEN_W'(cfg[a].gain);
      end

      always_ff @(posedge clock) begin
         if (adv[0]) begin
            field_ff[a] <= field[a];
            rate_ff[a] <= rate[a];
         end
         if (adv[1]) begin
            pa_ff[a] <= pa_in[a];
            pb_ff[a] <= pb_in[a];
         end
         if (adv[2]) c_ff[a] <= c_in[a];
         if (adv[3]) ax_ff[a] <= ax_in[a];
      end

      assign ax[a] = ax_ff[a];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) z1_ff <= z1_in;
      if (adv[2]) z2_ff <= z1_ff;
      if (adv[3]) z3_ff <= z2_ff;
   end

   assign zero = z3_ff;

endmodule
`default_nettype wire

[src/rcfc_axis.sv]
`default_nettype none
module rcfc_axis
   import rcfc_pkg::*;
(
   input  wire logic clock,
   input  wire logic [DIV_STAGES:0] adv,
   input  wire axis_in_type ax,
   output logic signed [CUR_W-1:0] current
);

   // Two restoring dividers run side by side: one for the raw current and
   // one for the current allowed by the dipole limit.
   div_type da_ff [DIV_STAGES];
   div_type db_ff [DIV_STAGES];
   tag_type tag_ff [DIV_STAGES];
   logic signed [CUR_W-1:0] cur_ff, cur_in;
   logic [QBITS-1:0] qa, qb, lim, mag;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         da_ff[0] <= div_start(ax.num, ax.den);
         db_ff[0] <= div_start(ax.lnum, ax.lden);
         tag_ff[0] <= ax.tag;
      end
   end

   for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
      localparam int B = QBITS - k;
      localparam logic [QBITS-1:0] QBIT = QBITS'(1) << B;
      always_ff @(posedge clock) begin
         if (adv[k]) begin
            da_ff[k] <= div_step(da_ff[k-1], NUM_W'(da_ff[k-1].den) << B, QBIT);
            db_ff[k] <= div_step(db_ff[k-1], NUM_W'(db_ff[k-1].den) << B, QBIT);
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   always_comb begin
      qa = da_ff[DIV_STAGES-1].sat ? '1 : da_ff[DIV_STAGES-1].q;
      qb = db_ff[DIV_STAGES-1].sat ? '1 : db_ff[DIV_STAGES-1].q;
      lim = (QBITS'(tag_ff[DIV_STAGES-1].ilim) < qb) ? QBITS'(tag_ff[DIV_STAGES-1].ilim) : qb;
      mag = (qa < lim) ? qa : lim;
      if (tag_ff[DIV_STAGES-1].off) begin
         cur_in = '0;
      end else if (tag_ff[DIV_STAGES-1].neg) begin
         cur_in = -$signed(CUR_W'(mag));
      end else begin
         cur_in = $signed(CUR_W'(mag));
      end
   end

   always_ff @(posedge clock) begin
      if (adv[DIV_STAGES]) cur_ff <= cur_in;
   end

   assign current = cur_ff;

endmodule
`default_nettype wire

[src/rate_cross_field_coil_current.sv]
`default_nettype none
// Cross-product detumble controller: each transaction carries a field sample
// (nT) and a body rate (urad/s) and returns three coil currents (uA) equal to
// 67.2 * (rate x field) / gain, truncated toward zero and clamped to the
// smaller of the current limit and dipole_limit * 1e9 / gain. A zero gain or
// limit silences that axis; an all-zero field returns zero currents with
// zero_field set. One transaction is accepted every cycle while results are
// taken; each passes four stages of multiply and cross product, then the
// 21-bit restoring dividers (one quotient bit per stage). Back-pressure
// stalls only the stages that hold data, so empty stages close up before
// the input is held off.
module rate_cross_field_coil_current
   import rcfc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   // field_x, field_y, field_z, rate_x, rate_y, rate_z, zero padding
   input  wire logic [127:0] req_tdata,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // coil_current_x, coil_current_y, coil_current_z, zero padding
   output logic [63:0] rsp_tdata,
   // zero_field
   output logic [0:0] rsp_tuser,
   input  wire logic csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [47:0] csr_wdata
);

   axis_cfg_type cfg_ff [AXES];
   logic [NUM_STAGES-1:0] v_ff, v_in, adv;
   logic signed [FIELD_W-1:0] field [AXES];
   logic signed [RATE_W-1:0] rate [AXES];
   axis_in_type ax [AXES];
   logic signed [CUR_W-1:0] current [AXES];
   logic zero_front;
   logic [DIV_STAGES:0] z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) cfg_ff[a] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_GAIN_X: cfg_ff[0].gain <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_Y: cfg_ff[1].gain <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_Z: cfg_ff[2].gain <= csr_wdata[GAIN_W-1:0];
            REG_ILIM_X: cfg_ff[0].ilim <= csr_wdata[ILIM_W-1:0];
            REG_ILIM_Y: cfg_ff[1].ilim <= csr_wdata[ILIM_W-1:0];
            REG_ILIM_Z: cfg_ff[2].ilim <= csr_wdata[ILIM_W-1:0];
            REG_DLIM: begin
               cfg_ff[0].dlim <= csr_wdata[15:0];
               cfg_ff[1].dlim <= csr_wdata[31:16];
               cfg_ff[2].dlim <= csr_wdata[47:32];
            end
            default: ;
         endcase
      end
   end

   // A stage may load when it is empty or when the stage after it moves.
   always_comb begin
      adv[NUM_STAGES-1] = !v_ff[NUM_STAGES-1] || rsp_tready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) adv[i] = !v_ff[i] || adv[i+1];
      v_in[0] = adv[0] ? req_tvalid : v_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) v_in[i] = adv[i] ? v_ff[i-1] : v_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= v_in;
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = v_ff[NUM_STAGES-1];

   for (genvar a = 0; a < AXES; a++) begin : g_unpack
      assign field[a] = req_tdata[a*FIELD_W +: FIELD_W];
      assign rate[a] = req_tdata[AXES*FIELD_W + a*RATE_W +: RATE_W];
   end

   rcfc_front u_front (
      .clock(clock),
      .adv(adv[FRONT_STAGES-1:0]),
      .field(field),
      .rate(rate),
      .cfg(cfg_ff),
      .ax(ax),
      .zero(zero_front)
   );

   for (genvar a = 0; a < AXES; a++) begin : g_axis
      rcfc_axis u_axis (
         .clock(clock),
         .adv(adv[NUM_STAGES-1:FRONT_STAGES]),
         .ax(ax[a]),
         .current(current[a])
      );
   end

   always_ff @(posedge clock) begin
      if (adv[FRONT_STAGES]) z_ff[0] <= zero_front;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         if (adv[FRONT_STAGES+k]) z_ff[k] <= z_ff[k-1];
      end
   end

   assign rsp_tdata = {1'b0, current[2], current[1], current[0]};
   assign rsp_tuser = z_ff[DIV_STAGES];

   a_zero_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("zero field transaction carries a non-zero current");

   a_ready_only_on_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input held off while the result side is not stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule
`default_nettype wire

[verif/tb.sv]
`default_nettype none
module tb;
   import rcfc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [127:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [47:0] csr_wdata = '0;

   typedef struct packed {
      logic [20:0] cx;
      logic [20:0] cy;
      logic [20:0] cz;
      logic zf;
   } current_cmd_type;

   current_cmd_type expected_currents[$];
   logic [23:0] gain_reg[3];
   logic [19:0] ilim_reg[3];
   logic [47:0] dlim_reg;
   int mismatches = 0;
   longint cycle_count = 0;

   rate_cross_field_coil_current u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   function automatic logic [20:0] axis_current(longint dip, logic [23:0] g, logic [19:0] il,
                                                logic [15:0] dl);
      longint raw, lim, dlv;
      if (g == 0 || il == 0 || dl == 0) return '0;
      raw = dip / (longint'(g) * 1000);
      dlv = (longint'(dl) * 1000000000) / longint'(g);
      lim = (longint'(il) < dlv) ? longint'(il) : dlv;
      if (raw > lim) raw = lim;
      if (raw < -lim) raw = -lim;
      return raw[20:0];
   endfunction

   function automatic current_cmd_type detumble_currents(logic [127:0] d);
      longint bx, by, bz, wx, wy, wz;
      current_cmd_type r;
      bx = longint'($signed(d[17:0]));
      by = longint'($signed(d[35:18]));
      bz = longint'($signed(d[53:36]));
      wx = longint'($signed(d[76:54]));
      wy = longint'($signed(d[99:77]));
      wz = longint'($signed(d[122:100]));
      r = '0;
      r.zf = (bx == 0 && by == 0 && bz == 0);
      if (!r.zf) begin
         r.cx = axis_current((wy * bz - wz * by) * 67200, gain_reg[0], ilim_reg[0],
                             dlim_reg[15:0]);
         r.cy = axis_current((wz * bx - wx * bz) * 67200, gain_reg[1], ilim_reg[1],
                             dlim_reg[31:16]);
         r.cz = axis_current((wx * by - wy * bx) * 67200, gain_reg[2], ilim_reg[2],
                             dlim_reg[47:32]);
      end
      return r;
   endfunction

   // Random receiver stalls when stall_mode is non-zero, mostly short with the odd long one.
   int stall_mode = 0;
   int stall_hold = 0;
   always @(posedge clock) begin
      if (stall_mode == 0) begin
         rsp_tready <= 1'b1;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
         stall_hold <= $urandom_range(10, 40);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      current_cmd_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[20:0], rsp_tdata[41:21], rsp_tdata[62:42], rsp_tuser[0]};
         if (expected_currents.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %h", got);
         end else begin
            want = expected_currents.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected x=%0d y=%0d z=%0d zf=%0d, got x=%0d y=%0d z=%0d zf=%0d",
                           $signed(want.cx), $signed(want.cy), $signed(want.cz), want.zf,
                           $signed(got.cx), $signed(got.cy), $signed(got.cz), got.zf);
            end
         end
      end
   end

   task automatic send_sample(logic [17:0] bx, by, bz, logic [22:0] wx, wy, wz);
      int gap;
      if (stall_mode != 0 && $urandom_range(0, 2) == 0) begin
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {5'b0, wz, wy, wx, bz, by, bx};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_currents.push_back(detumble_currents({5'b0, wz, wy, wx, bz, by, bx}));
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (expected_currents.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // The caller drops the write enable after its last write.
   task automatic write_reg(csr_index_type idx, logic [47:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         REG_GAIN_X: gain_reg[0] = v[23:0];
         REG_GAIN_Y: gain_reg[1] = v[23:0];
         REG_GAIN_Z: gain_reg[2] = v[23:0];
         REG_ILIM_X: ilim_reg[0] = v[19:0];
         REG_ILIM_Y: ilim_reg[1] = v[19:0];
         REG_ILIM_Z: ilim_reg[2] = v[19:0];
         REG_DLIM:   dlim_reg = v;
         default: ;
      endcase
   endtask

   task automatic set_config(logic [23:0] gx, gy, gz, logic [19:0] lx, ly, lz, logic [47:0] dl);
      drain();
      write_reg(REG_GAIN_X, {24'hFFFFFF, gx});
      write_reg(REG_GAIN_Y, gy);
      write_reg(REG_GAIN_Z, gz);
      write_reg(REG_ILIM_X, {28'hFFFFFFF, lx});
      write_reg(REG_ILIM_Y, ly);
      write_reg(REG_ILIM_Z, lz);
      write_reg(REG_DLIM, dl);
      csr_we <= 1'b0;
   endtask

   task automatic random_sample;
      logic [17:0] b[3];
      logic [22:0] w[3];
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 4))
            0: b[i] = 18'($signed($urandom_range(0, 200)) - 100);
            1: b[i] = $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
            2: b[i] = '0;
            default: b[i] = 18'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0: w[i] = 23'($signed($urandom_range(0, 2000)) - 1000);
            1: w[i] = $urandom_range(0, 1) ? 23'h3FFFFF : 23'h400000;
            default: w[i] = 23'($urandom);
         endcase
      end
      if ($urandom_range(0, 19) == 0) b = '{default: '0};
      send_sample(b[0], b[1], b[2], w[0], w[1], w[2]);
   endtask

   task automatic test_reset_defaults;
      for (int i = 0; i < 3; i++) begin
         gain_reg[i] = '0;
         ilim_reg[i] = '0;
      end
      dlim_reg = '0;
      send_sample(18'd1000, 18'd0, 18'd0, 23'd0, 23'd5000, 23'd0);
      send_sample(18'd0, 18'd0, 18'd0, 23'h3FFFFF, 23'h400000, 23'd1);
   endtask

   task automatic test_directed;
      set_config(24'd1, 24'd50000, 24'hFFFFFF, 20'hFFFFF, 20'd1000000, 20'd500,
                 48'hFFFF_FFFF_FFFF);
      send_sample(18'd0, 18'd0, 18'd0, 23'd100, 23'd100, 23'd100);
      send_sample(18'h1FFFF, 18'h20000, 18'h1FFFF, 23'h400000, 23'h3FFFFF, 23'h400000);
      send_sample(18'h20000, 18'h20000, 18'h20000, 23'h3FFFFF, 23'h3FFFFF, 23'h400000);
      send_sample(18'h3FFFF, 18'd1, 18'd0, 23'd1, 23'h7FFFFF, 23'd0);
      send_sample(18'd30000, 18'h3FFFF & -18'd20000, 18'd4000, 23'd1000, 23'd2000,
                  23'h7FFFFF & -23'd3000);
      send_sample(18'd1, 18'd0, 18'd0, 23'd0, 23'd0, 23'h3FFFFF);
      set_config(24'd0, 24'd3000, 24'd3000, 20'd1000, 20'd0, 20'd800, 48'h0001_0000_0002);
      send_sample(18'd30000, 18'd20000, 18'd4000, 23'd100000, 23'd2000, 23'h7FFFFF);
      send_sample(18'h20000, 18'h1FFFF, 18'd7, 23'h400000, 23'h3FFFFF, 23'd9);
      send_sample(18'd5, 18'd0, 18'd0, 23'd0, 23'd7, 23'd3);
   endtask

   task automatic test_random_phase(int n);
      logic [23:0] g[3];
      logic [19:0] l[3];
      logic [47:0] dl;
      for (int i = 0; i < 3; i++) begin
         g[i] = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(0, 1) * 24'hFFFFFF)
                                            : 24'($urandom_range(1, 200000));
         l[i] = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 1000000));
      end
      dl = 48'({$urandom, $urandom});
      if ($urandom_range(0, 3) == 0) dl = {16'($urandom_range(0, 50)), 16'($urandom_range(0, 50)),
                                           16'($urandom_range(0, 50))};
      set_config(g[0], g[1], g[2], l[0], l[1], l[2], dl);
      stall_mode = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) random_sample();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed();
      for (int p = 0; p < 15; p++) test_random_phase(100);
      drain();
      if (mismatches == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end
endmodule
`default_nettype wire
